### sv/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/ils_pkg.sv
// Shared codes and the command and status types between controller and datapath of the indexed list stack.
`default_nettype none

package ils_pkg;

  localparam int OP_BITS     = 3;
  localparam int STATUS_BITS = 2;

  localparam logic [OP_BITS-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_BITS-1:0] OP_POP    = 3'd1;
  localparam logic [OP_BITS-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_BITS-1:0] OP_REMOVE = 3'd3;
  localparam logic [OP_BITS-1:0] OP_SET    = 3'd4;
  localparam logic [OP_BITS-1:0] OP_GET    = 3'd5;

  localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

  // Read address selects.
  localparam logic [1:0] RA_TOP    = 2'd0;
  localparam logic [1:0] RA_POS    = 2'd1;
  localparam logic [1:0] RA_IDX_DN = 2'd2;
  localparam logic [1:0] RA_IDX_UP = 2'd3;

  // Write address selects.
  localparam logic [1:0] WA_COUNT = 2'd0;
  localparam logic [1:0] WA_POS   = 2'd1;
  localparam logic [1:0] WA_IDX   = 2'd2;

  // Index register operations.
  localparam logic [2:0] IDX_HOLD  = 3'd0;
  localparam logic [2:0] IDX_COUNT = 3'd1;
  localparam logic [2:0] IDX_POS   = 3'd2;
  localparam logic [2:0] IDX_DEC   = 3'd3;
  localparam logic [2:0] IDX_INC   = 3'd4;

  // Fill count operations.
  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;

  typedef struct packed {
    logic                   req_load;
    logic                   pos_clamp;
    logic                   rd_en;
    logic [1:0]             rd_sel;
    logic                   wr_en;
    logic [1:0]             wr_sel;
    logic                   wr_from_read;
    logic [2:0]             idx_op;
    logic [1:0]             cnt_op;
    logic                   out_load;
    logic                   word_sel;
    logic [STATUS_BITS-1:0] status;
  } ils_cmd_t;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic               full;
    logic               empty;
    logic               pos_oob;
    logic               idx_at_pos;
    logic               idx_last;
  } ils_sts_t;

endpackage

`default_nettype wire

### sv/indexed_list_stack.sv
// Top level of the indexed list stack: controller and datapath joined by command and status.
`default_nettype none

// An ordered list of up to DEPTH words that also works as a stack, held in a single-port
// memory. Each request is a push, pop, insert, remove, set or get and gives one result
// with the word read, the count after the request and a status. Requests are taken one
// at a time. Each request passes through decode and finish; insert and remove also step
// through a read and a write state per moved entry (count - clamped position entries for
// insert, count - position - 1 for remove), as each moved entry costs one read and one
// write of the memory port. Finish waits while an untaken result is held. A new request
// is taken in idle, even while the previous result still waits in the output register.
// Memory entries need no clearing after reset.
module indexed_list_stack #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic        [ils_pkg::OP_BITS-1:0]     in_op,
  input  wire logic        [AW-1:0]                   in_position,
  input  wire logic signed [WORD_BITS-1:0]            in_word_in,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed      [WORD_BITS-1:0]            out_word_out,
  output logic             [CW-1:0]                   out_count,
  output logic             [ils_pkg::STATUS_BITS-1:0] out_status
);

  ils_pkg::ils_cmd_t cmd;
  ils_pkg::ils_sts_t sts;

  ils_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ils_datapath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_op        (in_op),
    .in_position  (in_position),
    .in_word_in   (in_word_in),
    .out_word_out (out_word_out),
    .out_count    (out_count),
    .out_status   (out_status),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

`default_nettype wire

### sv/ils_ctrl.sv
// Controller state machine that sequences each request of the indexed list stack.
`default_nettype none

module ils_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire ils_pkg::ils_sts_t sts,
  output ils_pkg::ils_cmd_t   cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_INS_RD = 3'd2;
  localparam logic [2:0] ST_INS_WR = 3'd3;
  localparam logic [2:0] ST_REM_RD = 3'd4;
  localparam logic [2:0] ST_REM_WR = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0]                      state_r, state_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [ils_pkg::STATUS_BITS-1:0] status_r, status_nxt;
  logic                            rd_ok_r, rd_ok_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.idx_op    = ils_pkg::IDX_HOLD;
    cmd.cnt_op    = ils_pkg::CNT_HOLD;
    cmd.status    = status_r;
    cmd.word_sel  = rd_ok_r;
    state_nxt     = state_r;
    status_nxt    = status_r;
    rd_ok_nxt     = rd_ok_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.req_load = 1'b1;
          state_nxt    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        status_nxt = ils_pkg::STATUS_OK;
        rd_ok_nxt  = 1'b0;
        state_nxt  = ST_FINISH;
        unique case (sts.op)
          ils_pkg::OP_PUSH: begin
            if (sts.full) begin
              status_nxt = ils_pkg::STATUS_FULL;
            end else begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = ils_pkg::WA_COUNT;
              cmd.cnt_op = ils_pkg::CNT_INC;
            end
          end
          ils_pkg::OP_POP: begin
            if (sts.empty) begin
              status_nxt = ils_pkg::STATUS_RANGE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = ils_pkg::RA_TOP;
              cmd.cnt_op = ils_pkg::CNT_DEC;
              rd_ok_nxt  = 1'b1;
            end
          end
          ils_pkg::OP_INSERT: begin
            if (sts.full) begin
              status_nxt = ils_pkg::STATUS_FULL;
            end else begin
              cmd.pos_clamp = 1'b1;
              cmd.idx_op    = ils_pkg::IDX_COUNT;
              state_nxt     = ST_INS_RD;
            end
          end
          ils_pkg::OP_REMOVE: begin
            if (sts.pos_oob) begin
              status_nxt = ils_pkg::STATUS_RANGE;
            end else begin
              cmd.idx_op = ils_pkg::IDX_POS;
              state_nxt  = ST_REM_RD;
            end
          end
          ils_pkg::OP_SET: begin
            if (sts.pos_oob) begin
              status_nxt = ils_pkg::STATUS_RANGE;
            end else begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = ils_pkg::WA_POS;
            end
          end
          ils_pkg::OP_GET: begin
            if (sts.pos_oob) begin
              status_nxt = ils_pkg::STATUS_RANGE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = ils_pkg::RA_POS;
              rd_ok_nxt  = 1'b1;
            end
          end
          default: begin
            status_nxt = ils_pkg::STATUS_OK;
          end
        endcase
      end
      ST_INS_RD: begin
        if (sts.idx_at_pos) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = ils_pkg::WA_POS;
          cmd.cnt_op = ils_pkg::CNT_INC;
          state_nxt  = ST_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ils_pkg::RA_IDX_DN;
          state_nxt  = ST_INS_WR;
        end
      end
      ST_INS_WR: begin
        cmd.wr_en        = 1'b1;
        cmd.wr_sel       = ils_pkg::WA_IDX;
        cmd.wr_from_read = 1'b1;
        cmd.idx_op       = ils_pkg::IDX_DEC;
        state_nxt        = ST_INS_RD;
      end
      ST_REM_RD: begin
        if (sts.idx_last) begin
          cmd.cnt_op = ils_pkg::CNT_DEC;
          state_nxt  = ST_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ils_pkg::RA_IDX_UP;
          state_nxt  = ST_REM_WR;
        end
      end
      ST_REM_WR: begin
        cmd.wr_en        = 1'b1;
        cmd.wr_sel       = ils_pkg::WA_IDX;
        cmd.wr_from_read = 1'b1;
        cmd.idx_op       = ils_pkg::IDX_INC;
        state_nxt        = ST_REM_RD;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    rd_ok_r  <= rd_ok_nxt;
  end

endmodule

`default_nettype wire

### sv/ils_datapath.sv
// Datapath of the indexed list stack: entry memory, fill count, index and result registers.
`default_nettype none

module ils_datapath #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [ils_pkg::OP_BITS-1:0]     in_op,
  input  wire logic [AW-1:0]                   in_position,
  input  wire logic [WORD_BITS-1:0]            in_word_in,
  output logic      [WORD_BITS-1:0]            out_word_out,
  output logic      [CW-1:0]                   out_count,
  output logic      [ils_pkg::STATUS_BITS-1:0] out_status,
  input  wire ils_pkg::ils_cmd_t               cmd,
  output ils_pkg::ils_sts_t                    sts
);

  logic [WORD_BITS-1:0]            mem_r [DEPTH];
  logic [WORD_BITS-1:0]            rd_data_r;
  logic [ils_pkg::OP_BITS-1:0]     op_r;
  logic [AW-1:0]                   pos_r;
  logic [WORD_BITS-1:0]            word_r;
  logic [AW-1:0]                   idx_r, idx_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic [WORD_BITS-1:0]            word_out_r;
  logic [CW-1:0]                   count_out_r;
  logic [ils_pkg::STATUS_BITS-1:0] status_out_r;
  logic [AW-1:0]                   rd_addr;
  logic [AW-1:0]                   wr_addr;
  logic [WORD_BITS-1:0]            wr_data;

  assign sts.op         = op_r;
  assign sts.full       = (count_r == CW'(DEPTH));
  assign sts.empty      = (count_r == '0);
  assign sts.pos_oob    = (CW'(pos_r) >= count_r);
  assign sts.idx_at_pos = (idx_r == pos_r);
  assign sts.idx_last   = ((CW'(idx_r) + CW'(1)) >= count_r);

  always_comb begin
    unique case (cmd.rd_sel)
      ils_pkg::RA_TOP:    rd_addr = AW'(count_r - CW'(1));
      ils_pkg::RA_POS:    rd_addr = pos_r;
      ils_pkg::RA_IDX_DN: rd_addr = idx_r - AW'(1);
      default:            rd_addr = idx_r + AW'(1);
    endcase
  end

  always_comb begin
    unique case (cmd.wr_sel)
      ils_pkg::WA_COUNT: wr_addr = AW'(count_r);
      ils_pkg::WA_POS:   wr_addr = pos_r;
      default:           wr_addr = idx_r;
    endcase
  end

  assign wr_data = cmd.wr_from_read ? rd_data_r : word_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_comb begin
    unique case (cmd.idx_op)
      ils_pkg::IDX_COUNT: idx_nxt = AW'(count_r);
      ils_pkg::IDX_POS:   idx_nxt = pos_r;
      ils_pkg::IDX_DEC:   idx_nxt = idx_r - AW'(1);
      ils_pkg::IDX_INC:   idx_nxt = idx_r + AW'(1);
      default:            idx_nxt = idx_r;
    endcase
  end

  always_comb begin
    unique case (cmd.cnt_op)
      ils_pkg::CNT_INC: count_nxt = count_r + CW'(1);
      ils_pkg::CNT_DEC: count_nxt = count_r - CW'(1);
      default:          count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.req_load) begin
      op_r   <= in_op;
      pos_r  <= in_position;
      word_r <= in_word_in;
    end else if (cmd.pos_clamp && (CW'(pos_r) > count_r)) begin
      pos_r <= AW'(count_r);
    end
    if (cmd.out_load) begin
      word_out_r   <= cmd.word_sel ? rd_data_r : '0;
      count_out_r  <= count_r;
      status_out_r <= cmd.status;
    end
  end

  assign out_word_out = word_out_r;
  assign out_count    = count_out_r;
  assign out_status   = status_out_r;

endmodule

`default_nettype wire

### sv/ils_checker.sv
// Port-level checker for the indexed list stack and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module ils_checker #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [WORD_BITS-1:0]            out_word_out,
  input wire logic [CW-1:0]                   out_count,
  input wire logic [ils_pkg::STATUS_BITS-1:0] out_status
);

  // A stalled result must hold.
  `ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word_out) && $stable(out_count) && $stable(out_status))

  // The reported count never exceeds the store depth.
  `ASSERT_IMP(a_count_max, out_valid, out_count <= CW'(DEPTH))

  // A full report only comes from a full store.
  `ASSERT_IMP(a_full_count, out_valid && (out_status == ils_pkg::STATUS_FULL), out_count == CW'(DEPTH))

  // A failed request returns a zero word.
  `ASSERT_IMP(a_fail_zero, out_valid && (out_status != ils_pkg::STATUS_OK), out_word_out == '0)

  // A request taken while idle is never taken again in the next cycle.
  `ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

endmodule

bind indexed_list_stack ils_checker #(
  .DEPTH     (DEPTH),
  .WORD_BITS (WORD_BITS)
) u_ils_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_word_out (out_word_out),
  .out_count    (out_count),
  .out_status   (out_status)
);

`default_nettype wire

### dv/indexed_list_stack_tb.sv
// Self-checking testbench for the indexed list stack: directed and random request traffic.
`default_nettype none

module indexed_list_stack_tb;

  localparam int LIST_DEPTH   = 64;
  localparam int WORD_W       = 32;
  localparam int POS_W        = 6;
  localparam int COUNT_W      = 7;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 140;
  localparam int MAX_GAP      = 40;
  localparam int PHASE_ITEMS  = 212;

  localparam logic [ils_pkg::OP_BITS-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [ils_pkg::OP_BITS-1:0] OP_SPARE_HI = 3'd7;

  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIXED  = 2;

  typedef struct packed {
    logic [WORD_W-1:0]               word;
    logic [COUNT_W-1:0]              count;
    logic [ils_pkg::STATUS_BITS-1:0] status;
  } list_result_t;

  class list_scoreboard;
    logic [WORD_W-1:0] words [LIST_DEPTH];
    int                fill;
    int                peak_fill;
    list_result_t      awaited[$];
    int                errors;
    int                results_seen;
    int                op_tally [8];
    int                full_hits;
    int                range_hits;

    function new();
      fill = 0;
      peak_fill = 0;
      errors = 0;
      results_seen = 0;
      full_hits = 0;
      range_hits = 0;
      foreach (op_tally[i]) op_tally[i] = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task report(input string what, input logic [WORD_W-1:0] got,
                input logic [WORD_W-1:0] want);
      $display("MISMATCH %s: got %0h, expected %0h (result %0d)", what, got, want,
               results_seen);
      errors++;
    endtask

    // Works out the result of one accepted request and updates the list copy.
    task note_request(input logic [ils_pkg::OP_BITS-1:0] op, input logic [POS_W-1:0] pos,
                      input logic [WORD_W-1:0] word);
      list_result_t r;
      int           at;
      r.word = '0;
      r.status = ils_pkg::STATUS_OK;
      op_tally[op]++;
      case (op)
        ils_pkg::OP_PUSH: begin
          if (fill >= LIST_DEPTH) begin
            r.status = ils_pkg::STATUS_FULL;
          end else begin
            words[fill] = word;
            fill++;
          end
        end
        ils_pkg::OP_POP: begin
          if (fill == 0) begin
            r.status = ils_pkg::STATUS_RANGE;
          end else begin
            fill--;
            r.word = words[fill];
          end
        end
        ils_pkg::OP_INSERT: begin
          if (fill >= LIST_DEPTH) begin
            r.status = ils_pkg::STATUS_FULL;
          end else begin
            at = (int'(pos) > fill) ? fill : int'(pos);
            for (int i = fill; i > at; i--) words[i] = words[i-1];
            words[at] = word;
            fill++;
          end
        end
        ils_pkg::OP_REMOVE: begin
          if (int'(pos) >= fill) begin
            r.status = ils_pkg::STATUS_RANGE;
          end else begin
            for (int i = int'(pos); i + 1 < fill; i++) words[i] = words[i+1];
            fill--;
          end
        end
        ils_pkg::OP_SET: begin
          if (int'(pos) >= fill) r.status = ils_pkg::STATUS_RANGE;
          else words[pos] = word;
        end
        ils_pkg::OP_GET: begin
          if (int'(pos) >= fill) r.status = ils_pkg::STATUS_RANGE;
          else r.word = words[pos];
        end
        default: ;
      endcase
      if (r.status == ils_pkg::STATUS_FULL) full_hits++;
      if (r.status == ils_pkg::STATUS_RANGE) range_hits++;
      if (fill > peak_fill) peak_fill = fill;
      r.count = COUNT_W'(fill);
      awaited.push_back(r);
    endtask

    task check_result(input logic [WORD_W-1:0] word, input logic [COUNT_W-1:0] count,
                      input logic [ils_pkg::STATUS_BITS-1:0] status);
      list_result_t want;
      if (awaited.size() == 0) begin
        report("result with no request pending", word, '0);
      end else begin
        want = awaited.pop_front();
        if (word !== want.word) report("word_out", word, want.word);
        if (count !== want.count) report("count", WORD_W'(count), WORD_W'(want.count));
        if (status !== want.status) report("status", WORD_W'(status), WORD_W'(want.status));
      end
      results_seen++;
    endtask
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic [ils_pkg::OP_BITS-1:0]     in_op;
  logic [POS_W-1:0]                in_position;
  logic signed [WORD_W-1:0]        in_word_in;
  logic                            out_valid;
  logic                            out_ready;
  logic signed [WORD_W-1:0]        out_word_out;
  logic [COUNT_W-1:0]              out_count;
  logic [ils_pkg::STATUS_BITS-1:0] out_status;

  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  bit             hold_start = 1'b0;
  bit             hold_active;
  int             cycle_count = 0;
  list_scoreboard ledger;

  indexed_list_stack #(
    .DEPTH(LIST_DEPTH),
    .WORD_BITS(WORD_W)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_position(in_position),
    .in_word_in(in_word_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word_out(out_word_out),
    .out_count(out_count),
    .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= !hold_active && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    hold_active = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_start) begin
        hold_start = 1'b0;
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      ledger.check_result(out_word_out, out_count, out_status);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results pending.", cycle_count,
               ledger.pending());
      $display("indexed_list_stack_tb: done, errors");
      $finish;
    end
  end

  task automatic send_request(input logic [ils_pkg::OP_BITS-1:0] op,
                              input logic [POS_W-1:0] pos,
                              input logic [WORD_W-1:0] word);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_position <= pos;
    in_word_in <= word;
    do @(posedge clk); while (!in_ready);
    ledger.note_request(op, pos, word);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [POS_W-1:0] pick_position(input int fill);
    int roll;
    int p;
    roll = $urandom_range(0, 9);
    if (roll < 5) p = (fill > 3) ? fill - $urandom_range(1, 3) : $urandom_range(0, 3);
    else if (roll < 8) p = $urandom_range(0, fill);
    else p = $urandom_range(0, LIST_DEPTH - 1);
    if (p > LIST_DEPTH - 1) p = LIST_DEPTH - 1;
    return POS_W'(p);
  endfunction

  function automatic logic [ils_pkg::OP_BITS-1:0] pick_op(input int mode);
    int roll;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_GROW: begin
        if (roll < 40) return ils_pkg::OP_PUSH;
        if (roll < 65) return ils_pkg::OP_INSERT;
        if (roll < 75) return ils_pkg::OP_GET;
        if (roll < 85) return ils_pkg::OP_SET;
        if (roll < 92) return ils_pkg::OP_POP;
        if (roll < 97) return ils_pkg::OP_REMOVE;
      end
      MODE_SHRINK: begin
        if (roll < 35) return ils_pkg::OP_POP;
        if (roll < 60) return ils_pkg::OP_REMOVE;
        if (roll < 72) return ils_pkg::OP_GET;
        if (roll < 82) return ils_pkg::OP_SET;
        if (roll < 90) return ils_pkg::OP_PUSH;
        if (roll < 96) return ils_pkg::OP_INSERT;
      end
      default: begin
        if (roll < 16) return ils_pkg::OP_PUSH;
        if (roll < 32) return ils_pkg::OP_POP;
        if (roll < 48) return ils_pkg::OP_INSERT;
        if (roll < 64) return ils_pkg::OP_REMOVE;
        if (roll < 80) return ils_pkg::OP_SET;
        if (roll < 96) return ils_pkg::OP_GET;
      end
    endcase
    return (roll[0]) ? OP_SPARE_HI : OP_SPARE_LO;
  endfunction

  task automatic run_phase(input int idle_pct, input int stall_pct, input bit with_hold);
    int mode;
    int chunk_left;
    chunk_left = 0;
    mode = MODE_GROW;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (chunk_left == 0) begin
        mode = $urandom_range(MODE_GROW, MODE_MIXED);
        chunk_left = $urandom_range(20, 90);
      end
      chunk_left--;
      if (with_hold && n == PHASE_ITEMS / 2) hold_start = 1'b1;
      send_request(pick_op(mode), pick_position(ledger.fill), $urandom);
    end
    wait_for_results();
  endtask

  initial begin
    ledger = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = ils_pkg::OP_PUSH;
    in_position = '0;
    in_word_in = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests: empty-list errors, extreme words, clamped insert, spare op codes.
    send_request(ils_pkg::OP_POP, '0, '0);
    send_request(ils_pkg::OP_GET, '0, '0);
    send_request(ils_pkg::OP_REMOVE, '0, '0);
    send_request(ils_pkg::OP_SET, '0, 32'h1234_5678);
    send_request(ils_pkg::OP_PUSH, '0, 32'h8000_0000);
    send_request(ils_pkg::OP_PUSH, '1, 32'h7FFF_FFFF);
    send_request(ils_pkg::OP_PUSH, '0, 32'h0000_0000);
    send_request(ils_pkg::OP_PUSH, '0, 32'hFFFF_FFFF);
    send_request(ils_pkg::OP_INSERT, '1, 32'hA5A5_A5A5);
    send_request(ils_pkg::OP_INSERT, '0, 32'h5A5A_5A5A);
    send_request(ils_pkg::OP_INSERT, POS_W'(2), 32'hC3C3_3C3C);
    send_request(ils_pkg::OP_GET, '0, '0);
    send_request(ils_pkg::OP_GET, '1, '0);
    send_request(ils_pkg::OP_SET, POS_W'(1), 32'hDEAD_BEEF);
    send_request(ils_pkg::OP_GET, POS_W'(1), '0);
    send_request(ils_pkg::OP_SET, '1, 32'h0F0F_0F0F);
    send_request(ils_pkg::OP_REMOVE, '0, '0);
    send_request(ils_pkg::OP_REMOVE, '1, '0);
    send_request(ils_pkg::OP_REMOVE, POS_W'(5), '0);
    send_request(OP_SPARE_LO, '1, '1);
    send_request(OP_SPARE_HI, '0, '1);
    send_request(ils_pkg::OP_POP, '0, '0);
    send_request(ils_pkg::OP_GET, POS_W'(4), '0);
    wait_for_results();

    run_phase(0, 0, 1'b1);
    run_phase(76, 0, 1'b0);
    run_phase(0, 76, 1'b0);
    run_phase(15, 15, 1'b1);

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d results over four traffic phases plus a receiver hold-off.",
             ledger.results_seen);
    $display("Peak fill %0d, %0d full rejections, %0d range rejections, %0d inserts.",
             ledger.peak_fill, ledger.full_hits, ledger.range_hits,
             ledger.op_tally[ils_pkg::OP_INSERT]);
    if (ledger.errors == 0) begin
      $display("indexed_list_stack_tb: done, clean");
    end else begin
      $display("indexed_list_stack_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
+incdir+sv
sv/ils_pkg.sv
sv/ils_ctrl.sv
sv/ils_datapath.sv
sv/indexed_list_stack.sv
sv/ils_checker.sv
dv/indexed_list_stack_tb.sv
